[hdl/cle_pkg.sv]
// Package for the circular list engine: operation and status codes and the
// fixed widths of the channel fields. Depends on nothing.
package cle_pkg;

  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 5;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t KIND_INS_HEAD = 3'd0;
  localparam kind_t KIND_INS_TAIL = 3'd1;
  localparam kind_t KIND_FIRST    = 3'd2;
  localparam kind_t KIND_NEXT     = 3'd3;
  localparam kind_t KIND_REMOVE   = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_NOCUR = 2'd3;

endpackage

[hdl/cle_if.sv]
// Valid/ready channel interfaces for the circular list engine: the operation
// channel and the result channel. Depends on cle_pkg.
interface cle_op_if;
  import cle_pkg::*;

  logic                     valid;
  logic                     ready;
  kind_t                    kind;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, kind, data_in, input ready);
  modport sink   (input valid, kind, data_in, output ready);
endinterface

interface cle_res_if;
  import cle_pkg::*;

  logic                     valid;
  logic                     ready;
  status_t                  status;
  logic signed [DATA_W-1:0] data_out;
  logic [COUNT_W-1:0]       entry_count;

  modport source (output valid, status, data_out, entry_count, input ready);
  modport sink   (input valid, status, data_out, entry_count, output ready);
endinterface

[hdl/circular_list_engine.sv]
// Top level of the circular list engine: sequencer, list registers and the
// three slot memories. Depends on cle_pkg, cle_if (cle_op_if, cle_res_if) and cle_ram.

// The engine holds a bounded circular singly linked list of up to CAPACITY
// entries in three synchronous RAMs: slot values, slot links and a stack of
// free slot numbers. Go-to-first, remove and every rejected or unknown
// operation finish in the step state; an accepted insert or step to the next
// entry goes on to the done state. The done state comes from a dependent
// memory access: a step reads the link of the cursor and then the value of
// the entry it points at, while an insert reads the free stack and then, on a
// non-empty list, needs two link writes through the single write port of the
// link RAM. Operations run one at a time and every access of an operation
// sees the writes of the one before it, so no forwarding is needed. The
// result sits in an output register, so a new operation is accepted while
// the previous result beat still waits; only when a finished result meets a
// full output register does the engine hold its last step. No clearing pass
// runs after reset: the free stack is served from a low-water mark, below
// which an entry stands for its own index. An accepted insert clears the
// cursor, so a step or remove after it needs a fresh go-to-first.
module circular_list_engine #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input logic      clk,
  input logic      rst,
  cle_op_if.sink   op,
  cle_res_if.source res
);
  import cle_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_STEP, S_DONE} state_t;

  state_t state;

  // Latched operation
  kind_t                    op_kind;
  status_t                  op_status;
  logic                     op_ok;
  logic signed [DATA_W-1:0] din_q;

  // List registers
  logic [CNT_W-1:0] held_count;
  logic [CNT_W-1:0] free_top;
  logic [CNT_W-1:0] low_mark;
  logic [IDX_W-1:0] tail_slot;
  logic [IDX_W-1:0] head_slot;
  logic [IDX_W-1:0] cursor_slot;
  logic [IDX_W-1:0] prior_slot;
  logic             cursor_valid;
  logic [IDX_W-1:0] new_slot;

  // Output register
  logic                     res_valid;
  status_t                  res_status;
  logic signed [DATA_W-1:0] res_data;
  logic [COUNT_W-1:0]       res_count;

  // Memory ports
  logic                  val_we, val_re;
  logic [IDX_W-1:0]      val_waddr, val_raddr;
  logic [VALUE_BITS-1:0] val_wdata, val_rdata;
  logic                  link_we, link_re;
  logic [IDX_W-1:0]      link_waddr, link_raddr, link_wdata, link_rdata;
  logic                  fs_we, fs_re;
  logic [IDX_W-1:0]      fs_waddr, fs_raddr, fs_wdata, fs_rdata;

  // Control
  logic             in_fire;
  logic             out_free;
  logic             fin;
  status_t          acc_status;
  logic             acc_act;
  logic             is_ins, is_next, is_rem, is_first;
  logic [CNT_W-1:0] top_cnt;
  logic [IDX_W-1:0] top_idx;
  logic [IDX_W-1:0] alloc_slot;
  logic [CNT_W-1:0] held_after;
  logic signed [63:0] din_wide;
  logic signed [63:0] val_wide;
  logic signed [DATA_W-1:0] fin_data;

  assign op.ready    = (state == S_IDLE);
  assign in_fire     = op.valid && op.ready;
  assign out_free    = !res_valid || res.ready;

  assign res.valid       = res_valid;
  assign res.status      = res_status;
  assign res.data_out    = res_data;
  assign res.entry_count = res_count;

  assign is_ins   = (op_kind == KIND_INS_HEAD) || (op_kind == KIND_INS_TAIL);
  assign is_next  = (op_kind == KIND_NEXT);
  assign is_rem   = (op_kind == KIND_REMOVE);
  assign is_first = (op_kind == KIND_FIRST);

  // The top of the free stack; entries below the low-water mark were never
  // pushed; their own slot number is used in place of the stored entry.
  assign top_cnt    = free_top - CNT_W'(1);
  assign top_idx    = top_cnt[IDX_W-1:0];
  assign alloc_slot = (top_cnt < low_mark) ? top_idx : fs_rdata;

  assign din_wide  = 64'(din_q);
  assign val_wdata = din_wide[VALUE_BITS-1:0];
  assign val_wide  = 64'(signed'(val_rdata));

  // The result is loaded in the last step of an operation, once the output
  // register can take it.
  assign fin = out_free &&
               (((state == S_STEP) && !(op_ok && (is_ins || is_next))) ||
                (state == S_DONE));

  // Data word of the result: the value read for go-to-first, remove and step,
  // zero for inserts and for every refused or unknown operation.
  assign fin_data = (op_ok && (((state == S_STEP) && (is_first || is_rem)) ||
                               ((state == S_DONE) && is_next))) ?
                    val_wide[DATA_W-1:0] : '0;

  // Status decided at acceptance from the list registers.
  always_comb begin
    acc_status = ST_OK;
    case (op.kind)
      KIND_INS_HEAD, KIND_INS_TAIL: begin
        if (held_count == CNT_W'(CAPACITY)) begin
          acc_status = ST_FULL;
        end
      end
      KIND_FIRST: begin
        if (held_count == '0) begin
          acc_status = ST_EMPTY;
        end
      end
      KIND_NEXT: begin
        if (held_count == '0) begin
          acc_status = ST_EMPTY;
        end else if (!cursor_valid) begin
          acc_status = ST_NOCUR;
        end
      end
      KIND_REMOVE: begin
        if (held_count == '0) begin
          acc_status = ST_EMPTY;
        end else if (!cursor_valid ||
                     (held_count > CNT_W'(1) && cursor_slot == prior_slot)) begin
          // With more than one entry, a cursor equal to its own predecessor
          // means the entry under it has already been removed.
          acc_status = ST_NOCUR;
        end
      end
      default: acc_status = ST_OK;
    endcase
  end

  assign acc_act = (acc_status == ST_OK) && (op.kind <= KIND_REMOVE);

  always_comb begin
    held_after = held_count;
    if (op_ok && is_ins) begin
      held_after = held_count + CNT_W'(1);
    end else if (op_ok && is_rem) begin
      held_after = held_count - CNT_W'(1);
    end
  end

  // Memory port steering.
  always_comb begin
    val_re     = 1'b0;
    val_raddr  = cursor_slot;
    val_we     = 1'b0;
    val_waddr  = alloc_slot;
    link_re    = 1'b0;
    link_raddr = cursor_slot;
    link_we    = 1'b0;
    link_waddr = alloc_slot;
    link_wdata = (held_count == '0) ? alloc_slot : head_slot;
    fs_re      = 1'b0;
    fs_raddr   = top_idx;
    fs_we      = 1'b0;
    fs_waddr   = free_top[IDX_W-1:0];
    fs_wdata   = cursor_slot;

    if (in_fire && acc_act) begin
      case (op.kind)
        KIND_INS_HEAD, KIND_INS_TAIL: fs_re = 1'b1;
        KIND_FIRST: begin
          val_re    = 1'b1;
          val_raddr = head_slot;
        end
        KIND_NEXT: link_re = 1'b1;
        KIND_REMOVE: begin
          link_re = 1'b1;
          val_re  = 1'b1;
        end
        default: ;
      endcase
    end

    if (state == S_STEP && op_ok) begin
      if (is_ins) begin
        // New slot: value, and a link to the old head (or to itself).
        val_we  = 1'b1;
        link_we = 1'b1;
      end else if (is_next) begin
        val_re    = 1'b1;
        val_raddr = link_rdata;
      end else if (is_rem && out_free) begin
        // Unlink the cursor entry and push its slot onto the free stack.
        link_we    = 1'b1;
        link_waddr = prior_slot;
        link_wdata = link_rdata;
        fs_we      = 1'b1;
      end
    end

    if (state == S_DONE && op_ok && is_ins && out_free && held_count != '0) begin
      link_we    = 1'b1;
      link_waddr = tail_slot;
      link_wdata = new_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      res_valid    <= 1'b0;
      held_count   <= '0;
      free_top     <= CNT_W'(CAPACITY);
      low_mark     <= CNT_W'(CAPACITY);
      tail_slot    <= '0;
      head_slot    <= '0;
      cursor_slot  <= '0;
      prior_slot   <= '0;
      cursor_valid <= 1'b0;
    end else begin
      if (fin) begin
        res_valid  <= 1'b1;
        res_status <= op_status;
        res_count  <= COUNT_W'(held_after);
        res_data   <= fin_data;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            op_kind   <= op.kind;
            op_status <= acc_status;
            op_ok     <= acc_act;
            din_q     <= op.data_in;
            state     <= S_STEP;
          end
        end

        S_STEP: begin
          if (op_ok && is_ins) begin
            new_slot <= alloc_slot;
            state    <= S_DONE;
          end else if (op_ok && is_next) begin
            prior_slot  <= cursor_slot;
            cursor_slot <= link_rdata;
            state       <= S_DONE;
          end else if (out_free) begin
            if (op_ok && is_first) begin
              prior_slot   <= tail_slot;
              cursor_slot  <= head_slot;
              cursor_valid <= 1'b1;
            end else if (op_ok && is_rem) begin
              cursor_slot <= prior_slot;
              free_top    <= free_top + CNT_W'(1);
              held_count  <= held_after;
              if (cursor_slot == tail_slot && held_count > CNT_W'(1)) begin
                tail_slot <= prior_slot;
              end
              if (cursor_slot == head_slot) begin
                head_slot <= link_rdata;
              end
              if (held_after == '0) begin
                cursor_valid <= 1'b0;
              end
            end
            state <= S_IDLE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            if (is_ins) begin
              free_top     <= top_cnt;
              held_count   <= held_after;
              cursor_valid <= 1'b0;
              if (top_cnt < low_mark) begin
                low_mark <= top_cnt;
              end
              if (held_count == '0) begin
                head_slot <= new_slot;
                tail_slot <= new_slot;
              end else if (op_kind == KIND_INS_HEAD) begin
                head_slot <= new_slot;
              end else begin
                tail_slot <= new_slot;
              end
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  cle_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .re    (val_re),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  cle_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  cle_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_free_ram (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .re    (fs_re),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  // Every slot is either held in the list or on the free stack.
  a_slot_balance: assert property (@(posedge clk) disable iff (rst)
    (CNT_W + 1)'(held_count) + (CNT_W + 1)'(free_top) == (CNT_W + 1)'(CAPACITY))
    else $error("held and free slot counts do not add up to the capacity");

  // The low-water mark never rises above the free stack pointer.
  a_low_mark: assert property (@(posedge clk) disable iff (rst)
    low_mark <= free_top)
    else $error("free stack pointer below its low-water mark");

  // A valid cursor needs at least one entry.
  a_cursor_held: assert property (@(posedge clk) disable iff (rst)
    cursor_valid |-> held_count != '0)
    else $error("cursor valid on an empty list");

  // A finished operation always presents its result beat next cycle.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    fin |=> res_valid)
    else $error("finished operation produced no result beat");

  // An accepted operation closes the input until its result is loaded.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !op.ready)
    else $error("second operation accepted while one is in flight");

endmodule

[hdl/cle_ram.sv]
// Simple dual-port synchronous RAM for the list engine: one write port, one
// read port, read data registered from the address. No dependencies.
module cle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
